>>> sv/midpoint_ellipse_rasterizer_unit_assert.svh
// Assertion macros shared by the rasterizer RTL files.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_UNIT_ASSERT_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Implication or plain property, checked at every rising clock edge out of reset.
`define MER_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("rasterizer assertion failed");
// Condition that must never hold.
`define MER_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("rasterizer forbidden condition seen");
`else
`define MER_ASSERT(lbl, clk, rstn, prop)
`define MER_NEVER(lbl, clk, rstn, cond)
`endif
`endif

>>> sv/mer_pkg.sv
// Shared constants, codes and controller/datapath interface types.
package mer_pkg;

  localparam int unsigned CoordBitsDef = 10;

  // Input item operation codes
  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // Multiplier operand selections
  localparam logic [2:0] MUL_RX_RX   = 3'd0;
  localparam logic [2:0] MUL_RY_RY   = 3'd1;
  localparam logic [2:0] MUL_RX2_RY  = 3'd2;
  localparam logic [2:0] MUL_TX_TX   = 3'd3;
  localparam logic [2:0] MUL_RY2_P   = 3'd4;
  localparam logic [2:0] MUL_YM_YM   = 3'd5;
  localparam logic [2:0] MUL_RX2_P   = 3'd6;
  localparam logic [2:0] MUL_RX2_RY2 = 3'd7;

  // Decision register operations
  localparam logic [2:0] DEC_HOLD   = 3'd0;
  localparam logic [2:0] DEC_INIT   = 3'd1;
  localparam logic [2:0] DEC_STEP   = 3'd2;
  localparam logic [2:0] DEC_LOAD_P = 3'd3;
  localparam logic [2:0] DEC_ADD_P  = 3'd4;
  localparam logic [2:0] DEC_SUB_P  = 3'd5;

  typedef struct packed {
    logic       load_start;
    logic [2:0] mul_sel;
    logic [2:0] dec_op;
    logic       set_rx2;
    logic       set_ry2;
    logic       step_a;
    logic       emit;
    logic [1:0] pix;
  } mer_cmd_t;

  typedef struct packed {
    logic active;
    logic region_two;
    logic slope_lt;
    logic out_free;
  } mer_sts_t;

endpackage

>>> sv/mer_dpath.sv
// Rasterizer datapath: point state, shared multiplier, decision term and output register.
`include "midpoint_ellipse_rasterizer_unit_assert.svh"
module mer_dpath #(
  parameter int unsigned CoordBits = mer_pkg::CoordBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mer_pkg::mer_cmd_t           cmd_i,
  output mer_pkg::mer_sts_t           sts_o,
  input  logic [CoordBits-1:0]        center_x_i,
  input  logic [CoordBits-1:0]        center_y_i,
  input  logic [CoordBits-2:0]        radius_x_i,
  input  logic [CoordBits-2:0]        radius_y_i,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic signed [CoordBits+1:0] pixel_x_o,
  output logic signed [CoordBits+1:0] pixel_y_o,
  output logic                        last_o,
  output logic                        done_res_o
);
  import mer_pkg::*;

  localparam int unsigned RW  = CoordBits - 1;
  localparam int unsigned XW  = CoordBits;
  localparam int unsigned YW  = CoordBits + 1;
  localparam int unsigned SQW = 2 * RW;
  localparam int unsigned SW  = 3 * RW + 3;
  localparam int unsigned MW  = 2 * RW + 4;
  localparam int unsigned DW  = 4 * RW + 8;
  localparam int unsigned PW  = CoordBits + 2;

  logic [XW-1:0]        cx_q, cy_q;
  logic [RW-1:0]        rx_q, ry_q;
  logic [SQW-1:0]       rx2_q, ry2_q;
  logic [XW-1:0]        x_q, x_d;
  logic signed [YW-1:0] y_q, y_d;
  logic [SW-1:0]        sxt_q, sxt_d, syt_q, syt_d;
  logic signed [DW-1:0] dec_q, dec_d;
  logic [DW-1:0]        prod_q;
  logic                 reg2_q, reg2_d;
  logic                 active_q, active_d;
  logic                 xs_q, xs_d, ys_q, ys_d;

  logic                 out_valid_q;
  logic [PW-1:0]        px_q, py_q;
  logic                 last_q, done_q;

  logic [MW-1:0]        mul_a, mul_b;
  logic [XW:0]          tx;
  logic signed [YW-1:0] ym_s;
  logic signed [DW-1:0] sxt_e, syt_e, rx2_e, ry2_e, prod_e, dstep;
  logic                 neg, pos, take_x, take_y, out_free;
  logic [PW-1:0]        cx_e, cy_e, x_e, y_e, px_d, py_d;

  // Multiplier operands
  assign tx   = {x_q, 1'b1};
  assign ym_s = (y_q > 0) ? (y_q - YW'(1)) : (YW'(1) - y_q);

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_RX_RX: begin
        mul_a = MW'(rx_q);
        mul_b = MW'(rx_q);
      end
      MUL_RY_RY: begin
        mul_a = MW'(ry_q);
        mul_b = MW'(ry_q);
      end
      MUL_RX2_RY: begin
        mul_a = MW'(rx2_q);
        mul_b = MW'(ry_q);
      end
      MUL_TX_TX: begin
        mul_a = MW'(tx);
        mul_b = MW'(tx);
      end
      MUL_RY2_P: begin
        mul_a = MW'(ry2_q);
        mul_b = prod_q[MW-1:0];
      end
      MUL_YM_YM: begin
        mul_a = MW'(unsigned'(ym_s));
        mul_b = MW'(unsigned'(ym_s));
      end
      MUL_RX2_P: begin
        mul_a = MW'(rx2_q);
        mul_b = prod_q[MW-1:0];
      end
      MUL_RX2_RY2: begin
        mul_a = MW'(rx2_q);
        mul_b = MW'(ry2_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= DW'(mul_a) * DW'(mul_b);
  end

  // Extended terms for the decision arithmetic
  assign sxt_e  = signed'(DW'(sxt_q));
  assign syt_e  = signed'(DW'(syt_q));
  assign rx2_e  = signed'(DW'(rx2_q));
  assign ry2_e  = signed'(DW'(ry2_q));
  assign prod_e = signed'(prod_q);
  assign dstep  = (xs_q ? (sxt_e <<< 2) : '0) - (ys_q ? (syt_e <<< 2) : '0)
                + ((reg2_q ? rx2_e : ry2_e) <<< 2);

  // Step direction: region 1 always steps x, region 2 always steps y
  assign neg    = dec_q[DW-1];
  assign pos    = !neg && (dec_q != '0);
  assign take_x = reg2_q ? !pos : 1'b1;
  assign take_y = reg2_q ? 1'b1 : !neg;

  always_comb begin
    x_d      = x_q;
    y_d      = y_q;
    sxt_d    = sxt_q;
    syt_d    = syt_q;
    xs_d     = xs_q;
    ys_d     = ys_q;
    active_d = active_q;
    reg2_d   = reg2_q;
    dec_d    = dec_q;
    if (cmd_i.load_start) begin
      x_d      = '0;
      y_d      = signed'(YW'(radius_y_i));
      sxt_d    = '0;
      reg2_d   = 1'b0;
      active_d = 1'b1;
    end
    if (cmd_i.step_a) begin
      xs_d = take_x;
      ys_d = take_y;
      if (take_x) begin
        x_d   = x_q + XW'(1);
        sxt_d = sxt_q + SW'({ry2_q, 1'b0});
      end
      if (take_y) begin
        y_d   = y_q - YW'(1);
        syt_d = syt_q - SW'({rx2_q, 1'b0});
      end
      // Drop out of the ellipse once y walks below zero
      if (reg2_q && (y_q == '0)) begin
        active_d = 1'b0;
      end
    end
    unique case (cmd_i.dec_op)
      DEC_HOLD: ;
      DEC_INIT: begin
        syt_d = SW'({prod_q, 1'b0});
        dec_d = (ry2_e <<< 2) - (prod_e <<< 2) + rx2_e;
      end
      DEC_STEP:   dec_d = dec_q + dstep;
      DEC_LOAD_P: dec_d = prod_e;
      DEC_ADD_P:  dec_d = dec_q + (prod_e <<< 2);
      DEC_SUB_P: begin
        dec_d  = dec_q - (prod_e <<< 2);
        reg2_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      reg2_q   <= 1'b0;
    end else begin
      active_q <= active_d;
      reg2_q   <= reg2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    sxt_q <= sxt_d;
    syt_q <= syt_d;
    dec_q <= dec_d;
    xs_q  <= xs_d;
    ys_q  <= ys_d;
    if (cmd_i.load_start) begin
      cx_q <= center_x_i;
      cy_q <= center_y_i;
      rx_q <= radius_x_i;
      ry_q <= radius_y_i;
    end
    if (cmd_i.set_rx2) begin
      rx2_q <= prod_q[SQW-1:0];
    end
    if (cmd_i.set_ry2) begin
      ry2_q <= prod_q[SQW-1:0];
    end
  end

  // Pixel generation: pix bit 0 mirrors x, bit 1 mirrors y
  assign cx_e = PW'(cx_q);
  assign cy_e = PW'(cy_q);
  assign x_e  = PW'(x_q);
  assign y_e  = {{(PW-YW){y_q[YW-1]}}, y_q};
  assign px_d = cmd_i.pix[0] ? (cx_e - x_e) : (cx_e + x_e);
  assign py_d = cmd_i.pix[1] ? (cy_e - y_e) : (cy_e + y_e);

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      px_q   <= px_d;
      py_q   <= py_d;
      last_q <= (cmd_i.pix == 2'b11);
      done_q <= (cmd_i.pix == 2'b11) && reg2_q && (y_q[YW-1] || (y_q == '0));
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_x_o   = signed'(px_q);
  assign pixel_y_o   = signed'(py_q);
  assign last_o      = last_q;
  assign done_res_o  = done_q;

  assign sts_o.active     = active_q;
  assign sts_o.region_two = reg2_q;
  assign sts_o.slope_lt   = (sxt_q < syt_q);
  assign sts_o.out_free   = out_free;

  `MER_NEVER(a_active_y_nonneg, clk_i, rst_ni, active_q && y_q[YW-1])
  `MER_ASSERT(a_finish_in_region_two, clk_i, rst_ni, $fell(active_q) |-> reg2_q)
  `MER_ASSERT(a_done_only_on_last, clk_i, rst_ni, (out_valid_q && done_q) |-> last_q)

endmodule

>>> sv/mer_ctrl.sv
// Rasterizer controller: sequences start setup, region switch, pixel emission and stepping.
`include "midpoint_ellipse_rasterizer_unit_assert.svh"
module mer_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              operation_i,
  input  mer_pkg::mer_sts_t sts_i,
  output mer_pkg::mer_cmd_t cmd_o
);
  import mer_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MRX  = 4'd1;
  localparam logic [3:0] ST_MRY  = 4'd2;
  localparam logic [3:0] ST_MXY  = 4'd3;
  localparam logic [3:0] ST_INIT = 4'd4;
  localparam logic [3:0] ST_CHK  = 4'd5;
  localparam logic [3:0] ST_E0   = 4'd6;
  localparam logic [3:0] ST_E1   = 4'd7;
  localparam logic [3:0] ST_E2   = 4'd8;
  localparam logic [3:0] ST_E3   = 4'd9;
  localparam logic [3:0] ST_E4   = 4'd10;
  localparam logic [3:0] ST_E5   = 4'd11;
  localparam logic [3:0] ST_EMIT = 4'd12;
  localparam logic [3:0] ST_STA  = 4'd13;
  localparam logic [3:0] ST_STB  = 4'd14;

  logic [3:0] state_q, state_d;
  logic [1:0] pix_q, pix_d;
  logic       accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    pix_d   = pix_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (operation_i == OP_START) begin
            cmd_o.load_start = 1'b1;
            state_d          = ST_MRX;
          end else if (sts_i.active) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_MRX: begin
        cmd_o.mul_sel = MUL_RX_RX;
        state_d       = ST_MRY;
      end
      ST_MRY: begin
        cmd_o.set_rx2 = 1'b1;
        cmd_o.mul_sel = MUL_RY_RY;
        state_d       = ST_MXY;
      end
      ST_MXY: begin
        cmd_o.set_ry2 = 1'b1;
        cmd_o.mul_sel = MUL_RX2_RY;
        state_d       = ST_INIT;
      end
      ST_INIT: begin
        cmd_o.dec_op = DEC_INIT;
        state_d      = ST_CHK;
      end
      ST_CHK: begin
        state_d = sts_i.slope_lt ? ST_IDLE : ST_E0;
      end
      // Region 2 setup: ry2*(2x+1)^2 + 4*rx2*(y-1)^2 - 4*rx2*ry2
      ST_E0: begin
        cmd_o.mul_sel = MUL_TX_TX;
        state_d       = ST_E1;
      end
      ST_E1: begin
        cmd_o.mul_sel = MUL_RY2_P;
        state_d       = ST_E2;
      end
      ST_E2: begin
        cmd_o.dec_op  = DEC_LOAD_P;
        cmd_o.mul_sel = MUL_YM_YM;
        state_d       = ST_E3;
      end
      ST_E3: begin
        cmd_o.mul_sel = MUL_RX2_P;
        state_d       = ST_E4;
      end
      ST_E4: begin
        cmd_o.dec_op  = DEC_ADD_P;
        cmd_o.mul_sel = MUL_RX2_RY2;
        state_d       = ST_E5;
      end
      ST_E5: begin
        cmd_o.dec_op = DEC_SUB_P;
        state_d      = ST_IDLE;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.pix  = pix_q;
          pix_d      = pix_q + 2'd1;
          if (pix_q == 2'b11) begin
            state_d = ST_STA;
          end
        end
      end
      ST_STA: begin
        cmd_o.step_a = 1'b1;
        state_d      = ST_STB;
      end
      ST_STB: begin
        cmd_o.dec_op = DEC_STEP;
        state_d      = sts_i.region_two ? ST_IDLE : ST_CHK;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pix_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      pix_q   <= pix_d;
    end
  end

  `MER_ASSERT(a_emit_needs_room, clk_i, rst_ni, cmd_o.emit |-> sts_i.out_free)
  `MER_ASSERT(a_idle_pix_zero, clk_i, rst_ni, (state_q == ST_IDLE) |-> (pix_q == 2'd0))
  `MER_ASSERT(a_advance_emits, clk_i, rst_ni,
    (accept && (operation_i == OP_ADVANCE) && sts_i.active) |=> (state_q == ST_EMIT))

endmodule

>>> sv/midpoint_ellipse_rasterizer_unit.sv
// Top level of the midpoint ellipse rasterizer: controller plus datapath.
//
// Input channel (in_valid_i / in_stall_o): one item per command. A start item
// (operation_i = 0) latches the centre and the two semi-axes and sets up the
// first region; it produces no pixel. An advance item (operation_i = 1) emits
// the four mirrored pixels of the current quadrant point, in the order
// (+x,+y), (-x,+y), (+x,-y), (-x,-y), then steps the point. An advance while
// no ellipse is running is taken and dropped.
// Output channel (out_valid_o / out_stall_i): one pixel per item; last_o marks
// the fourth pixel of a point, done_res_o marks the final pixel of the ellipse.
// Timing: items are processed one at a time around one shared multiplier.
// A start squares both semi-axes and sets up the decision term, then checks
// the slopes. In region 1 an advance also checks the slopes after the step.
// When the switch from region 1 to region 2 falls after a start or a step,
// five products through the multiplier build the region-2 decision term.
// The input stalls while a command is in progress.
// Output stall: the single output register holds the pixel and the controller
// waits in emission; no pixel is lost or repeated.
// Reset: asynchronous, active low; the block comes up idle with no ellipse.
module midpoint_ellipse_rasterizer_unit #(
  parameter int unsigned CoordBits = mer_pkg::CoordBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        operation_i,
  input  logic [CoordBits-1:0]        center_x_i,
  input  logic [CoordBits-1:0]        center_y_i,
  input  logic [CoordBits-2:0]        radius_x_i,
  input  logic [CoordBits-2:0]        radius_y_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [CoordBits+1:0] pixel_x_o,
  output logic signed [CoordBits+1:0] pixel_y_o,
  output logic                        last_o,
  output logic                        done_res_o
);
  import mer_pkg::*;

  mer_cmd_t cmd;
  mer_sts_t sts;

  // Sequencer: owns the input handshake and issues one command per cycle
  mer_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Point state, decision arithmetic and the output register
  mer_dpath #(
    .CoordBits (CoordBits)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .center_x_i  (center_x_i),
    .center_y_i  (center_y_i),
    .radius_x_i  (radius_x_i),
    .radius_y_i  (radius_y_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .pixel_x_o   (pixel_x_o),
    .pixel_y_o   (pixel_y_o),
    .last_o      (last_o),
    .done_res_o  (done_res_o)
  );

endmodule
